// File: src/wrss_pkg.sv
`default_nettype none

package wrss_pkg;

   localparam int HEIGHT_W    = 32;
   localparam int COORD_W     = 10;
   localparam int CFG_SIZE_W  = 11;
   localparam int CFG_SHIFT_W = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CFG_SIZE_W-1:0]  FRAME_WIDTH_RST   = 11'd1024;
   localparam logic [CFG_SIZE_W-1:0]  FRAME_HEIGHT_RST  = 11'd1024;
   localparam logic [CFG_SHIFT_W-1:0] DAMPING_SHIFT_RST = 5'd6;
   localparam int MIN_SIZE = 3;

   typedef logic signed [HEIGHT_W-1:0] height_type;
   typedef logic [COORD_W-1:0]         coord_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_DAMPING_SHIFT = 2'd2
   } csr_index_type;

   // one line store entry: row r-2 and row r-1 at the same column
   typedef struct packed {
      height_type upper;
      height_type middle;
   } line_pair_type;

endpackage

`default_nettype wire

// File: src/wrss_req_if.sv
`default_nettype none

interface wrss_req_if
   import wrss_pkg::*;
   ;
   logic       valid;
   logic       ready;
   height_type cur_height;
   height_type older_height;
   logic       start_of_frame;

   modport source (output valid, output cur_height, output older_height,
                   output start_of_frame, input ready);
   modport sink   (input valid, input cur_height, input older_height,
                   input start_of_frame, output ready);
endinterface

`default_nettype wire

// File: src/wrss_rsp_if.sv
`default_nettype none

interface wrss_rsp_if
   import wrss_pkg::*;
   ;
   logic       valid;
   logic       ready;
   height_type new_height;
   coord_type  out_col;
   coord_type  out_row;

   modport source (output valid, output new_height, output out_col, output out_row,
                   input ready);
   modport sink   (input valid, input new_height, input out_col, input out_row,
                   output ready);
endinterface

`default_nettype wire

// File: src/wrss_csr_if.sv
`default_nettype none

interface wrss_csr_if
   import wrss_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/water_ripple_stencil_step_core.sv
`default_nettype none

// Channel   Dir  Modport  Payload
// req_bus   in   sink     cur_height, older_height, start_of_frame
// rsp_bus   out  source   new_height, out_col, out_row (interior pixels only)
// csr_bus   in   sink     index, data (always ready)
//
// One pixel per clock sustained while rsp_bus accepts; each pixel passes through the stages
// line store read, window update, neighbour sum, wave step, damping.
// The line store and older-height delay line are single-write, single-read memories;
// a same-column read right behind a write takes the bypass path.
// Synchronous reset clears counters, delay pointer, window and stage valids, and loads CSR defaults.
// Every stage holds independently, so pixels keep flowing into empty stages
// while a result waits on rsp_bus.

module water_ripple_stencil_step_core
   import wrss_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire         clock,
   input  wire         reset,
   wrss_req_if.sink    req_bus,
   wrss_rsp_if.source  rsp_bus,
   wrss_csr_if.sink    csr_bus
);

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int DLY_DEPTH = MAX_WIDTH + 2;
   localparam int PTR_W     = $clog2(DLY_DEPTH);

   // configuration
   logic [CFG_SIZE_W-1:0]  frame_width_ff;
   logic [CFG_SIZE_W-1:0]  frame_height_ff;
   logic [CFG_SHIFT_W-1:0] damping_shift_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         damping_shift_ff <= DAMPING_SHIFT_RST;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_bus.data[CFG_SIZE_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_bus.data[CFG_SIZE_W-1:0];
            CSR_DAMPING_SHIFT: damping_shift_ff <= csr_bus.data[CFG_SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp sizes to 3..MAX
   logic [31:0]    fw_ext, fh_ext;
   logic [COL_W:0] eff_w;
   logic [ROW_W:0] eff_h;

   always_comb begin
      fw_ext = 32'(frame_width_ff);
      fh_ext = 32'(frame_height_ff);
      if (fw_ext < 32'(MIN_SIZE))       eff_w = (COL_W+1)'(MIN_SIZE);
      else if (fw_ext > 32'(MAX_WIDTH)) eff_w = (COL_W+1)'(MAX_WIDTH);
      else                              eff_w = (COL_W+1)'(fw_ext);
      if (fh_ext < 32'(MIN_SIZE))        eff_h = (ROW_W+1)'(MIN_SIZE);
      else if (fh_ext > 32'(MAX_HEIGHT)) eff_h = (ROW_W+1)'(MAX_HEIGHT);
      else                               eff_h = (ROW_W+1)'(fh_ext);
   end

   // pipeline handshake
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, out_v_ff;
   logic ld_out, ld4, ld3, ld2, ld1, req_acc;

   assign ld_out  = !out_v_ff || rsp_bus.ready;
   assign ld4     = !s4_v_ff || ld_out;
   assign ld3     = !s3_v_ff || ld4;
   assign ld2     = !s2_v_ff || ld3;
   assign ld1     = !s1_v_ff || ld2;
   assign req_bus.ready = ld1;
   assign req_acc = req_bus.valid && ld1;

   // raster position
   logic [COL_W-1:0] col_ff, col_in, col_a, cur_c;
   logic [ROW_W-1:0] row_ff, row_in, row_a, cur_r;
   logic [ROW_W:0]   row_b, row_nx;
   logic [COL_W:0]   col_nx;

   always_comb begin
      col_a = req_bus.start_of_frame ? '0 : col_ff;
      row_a = req_bus.start_of_frame ? '0 : row_ff;
      // position left past the frame by a size change: wrap first
      if ({1'b0, col_a} >= eff_w) begin
         cur_c = '0;
         row_b = {1'b0, row_a} + (ROW_W+1)'(1);
      end else begin
         cur_c = col_a;
         row_b = {1'b0, row_a};
      end
      cur_r  = (row_b >= eff_h) ? '0 : row_b[ROW_W-1:0];
      col_nx = {1'b0, cur_c} + (COL_W+1)'(1);
      row_nx = {1'b0, cur_r} + (ROW_W+1)'(1);
      if (col_nx >= eff_w) begin
         col_in = '0;
         row_in = (row_nx >= eff_h) ? '0 : row_nx[ROW_W-1:0];
      end else begin
         col_in = col_nx[COL_W-1:0];
         row_in = cur_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // older-height delay line: centre value was written w+1 transactions ago
   height_type      dly_mem [DLY_DEPTH];
   logic [PTR_W-1:0] dly_ptr_ff, dly_ptr_in, dly_rd_addr;
   logic [PTR_W:0]   dly_rd_raw;
   height_type      dly_rd_ff;

   always_comb begin
      dly_rd_raw = {1'b0, dly_ptr_ff} + (PTR_W+1)'(DLY_DEPTH)
                   - (PTR_W+1)'(eff_w) - (PTR_W+1)'(1);
      if (dly_rd_raw >= (PTR_W+1)'(DLY_DEPTH))
         dly_rd_addr = PTR_W'(dly_rd_raw - (PTR_W+1)'(DLY_DEPTH));
      else
         dly_rd_addr = dly_rd_raw[PTR_W-1:0];
      if (dly_ptr_ff == PTR_W'(DLY_DEPTH - 1)) dly_ptr_in = '0;
      else                                     dly_ptr_in = dly_ptr_ff + PTR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         dly_mem[dly_ptr_ff] <= req_bus.older_height;
         dly_rd_ff           <= dly_mem[dly_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)        dly_ptr_ff <= '0;
      else if (req_acc) dly_ptr_ff <= dly_ptr_in;
   end

   // line store: {row r-2, row r-1} per column
   line_pair_type    line_mem [MAX_WIDTH];
   line_pair_type    line_rd_ff, byp_data_ff, line_res, line_wr;
   logic             byp_ff;
   height_type       s1_cur_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;

   always_comb begin
      line_res       = byp_ff ? byp_data_ff : line_rd_ff;
      line_wr.upper  = line_res.middle;
      line_wr.middle = s1_cur_ff;
   end

   // write every cycle the stage is occupied; rewriting while held is harmless
   always_ff @(posedge clock) begin
      if (s1_v_ff) line_mem[s1_col_ff] <= line_wr;
      if (req_acc) begin
         line_rd_ff  <= line_mem[cur_c];
         // same column written at this edge: read would miss it
         byp_ff      <= s1_v_ff && (s1_col_ff == cur_c);
         byp_data_ff <= line_wr;
         s1_cur_ff   <= req_bus.cur_height;
         s1_col_ff   <= cur_c;
         s1_row_ff   <= cur_r;
      end
   end

   // stage 2: window holds the 3x3 neighbourhood
   height_type       win_ff [9];
   height_type       s2_older_ff;
   logic             s2_emit_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic             s1_pass;

   assign s1_pass = s1_v_ff && ld2;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else if (s1_pass) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= line_res.upper;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= line_res.middle;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= s1_cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_older_ff <= dly_rd_ff;
         s2_emit_ff  <= ({1'b0, s1_col_ff} >= (COL_W+1)'(2))
                        && ({1'b0, s1_row_ff} >= (ROW_W+1)'(2));
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
      end
   end

   // stage 3: neighbour sum, wraps at 32 bits
   height_type sum_in, sum_ff, s3_older_ff;
   coord_type  s3_col_ff, s3_row_ff;
   logic [31:0] col_m1, row_m1;

   assign sum_in = ((win_ff[0] + win_ff[1]) + (win_ff[2] + win_ff[3]))
                 + ((win_ff[5] + win_ff[6]) + (win_ff[7] + win_ff[8]));
   assign col_m1 = 32'(s2_col_ff) - 32'd1;
   assign row_m1 = 32'(s2_row_ff) - 32'd1;

   always_ff @(posedge clock) begin
      if (ld3) begin
         sum_ff      <= sum_in;
         s3_older_ff <= s2_older_ff;
         s3_col_ff   <= col_m1[COORD_W-1:0];
         s3_row_ff   <= row_m1[COORD_W-1:0];
      end
   end

   // stage 4: wave step
   height_type newh_ff;
   coord_type  s4_col_ff, s4_row_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         newh_ff   <= (sum_ff >>> 2) - s3_older_ff;
         s4_col_ff <= s3_col_ff;
         s4_row_ff <= s3_row_ff;
      end
   end

   // output register: damping
   height_type res_ff;
   coord_type  out_col_ff, out_row_ff;

   always_ff @(posedge clock) begin
      if (ld_out) begin
         res_ff     <= newh_ff - (newh_ff >>> damping_shift_ff);
         out_col_ff <= s4_col_ff;
         out_row_ff <= s4_row_ff;
      end
   end

   // stage valids; border pixels drop out after stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (ld1)    s1_v_ff  <= req_bus.valid;
         if (ld2)    s2_v_ff  <= s1_v_ff;
         if (ld3)    s3_v_ff  <= s2_v_ff && s2_emit_ff;
         if (ld4)    s4_v_ff  <= s3_v_ff;
         if (ld_out) out_v_ff <= s4_v_ff;
      end
   end

   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.new_height = res_ff;
   assign rsp_bus.out_col    = out_col_ff;
   assign rsp_bus.out_row    = out_row_ff;

   // checks
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      dly_ptr_ff < PTR_W'(DLY_DEPTH - 1) || dly_ptr_ff == PTR_W'(DLY_DEPTH - 1))
      else $error("delay pointer past end of delay line");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(MAX_WIDTH) && 32'(row_ff) < 32'(MAX_HEIGHT))
      else $error("raster position out of range");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !ld2 |=> s1_v_ff && $stable(s1_col_ff) && $stable(s1_cur_ff))
      else $error("line stage lost a held transaction");

   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_v_ff && s1_col_ff == $past(cur_c))
      else $error("accepted transaction missing from line stage");

endmodule

`default_nettype wire

// File: tb/tb_water_ripple_stencil_step_core.sv
`timescale 1ns / 1ps

module tb_water_ripple_stencil_step_core;
   import wrss_pkg::*;

   localparam int FRAME_MAX    = 1024;
   localparam int RING_DEPTH   = FRAME_MAX + 2;
   localparam int NUM_REGS     = 3;
   localparam int WIN_CENTRE   = 4;
   localparam int SHIFT_MAX    = (1 << CFG_SHIFT_W) - 1;
   localparam int MAX_GAP      = 9;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 750;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int HALF_PERIOD  = 5;

   localparam height_type HEIGHT_MAX = height_type'(32'h7FFF_FFFF);
   localparam height_type HEIGHT_MIN = height_type'(32'h8000_0000);

   typedef struct {
      height_type cur;
      height_type older;
      logic       sof;
      bit         after_drain;
   } pixel_type;

   typedef struct {
      height_type new_height;
      coord_type  col;
      coord_type  row;
   } ripple_type;

   logic clock = 1'b0;
   logic reset;

   wrss_req_if req_bus ();
   wrss_rsp_if rsp_bus ();
   wrss_csr_if csr_bus ();

   water_ripple_stencil_step_core #(
      .MAX_WIDTH  (FRAME_MAX),
      .MAX_HEIGHT (FRAME_MAX)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow copy of the block's configuration and stencil state
   logic [CFG_SIZE_W-1:0]  cfg_width;
   logic [CFG_SIZE_W-1:0]  cfg_height;
   logic [CFG_SHIFT_W-1:0] cfg_shift;
   height_type             row_above2 [0:FRAME_MAX-1];
   height_type             row_above1 [0:FRAME_MAX-1];
   height_type             older_ring [0:RING_DEPTH-1];
   height_type             win [0:8];
   int unsigned            ring_wr;
   int unsigned            col_pos;
   int unsigned            row_pos;

   pixel_type   pixel_q [$];
   ripple_type  ripple_q [$];
   pixel_type   next_pixel;
   ripple_type  next_ripple;
   ripple_type  got_ripple;
   ripple_type  want_ripple;
   int unsigned send_gap;
   int unsigned rsp_stall;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          steady_flow = 1'b0;

   function automatic int unsigned effective_size(input logic [CFG_SIZE_W-1:0] v);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > FRAME_MAX) return FRAME_MAX;
      return 32'(v);
   endfunction

   function automatic bit predict_ripple(input height_type cur, input height_type older,
                                         input logic sof, output ripple_type want);
      int unsigned w, h, c, r, rd, k;
      height_type  older_centre, sum, newh;
      w = effective_size(cfg_width);
      h = effective_size(cfg_height);
      want = '{default: '0};
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      // position left past the frame by a size change wraps first
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;

      rd = (ring_wr + RING_DEPTH - (w + 1)) % RING_DEPTH;
      older_centre = older_ring[rd];
      older_ring[ring_wr] = older;
      ring_wr = (ring_wr + 1) % RING_DEPTH;

      for (k = 0; k < 3; k++) begin
         win[k * 3]     = win[k * 3 + 1];
         win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = row_above2[c];
      win[5] = row_above1[c];
      win[8] = cur;
      row_above2[c] = row_above1[c];
      row_above1[c] = cur;

      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end

      if (c < 2 || r < 2) return 1'b0;

      sum = '0;
      for (k = 0; k < 9; k++)
         if (k != WIN_CENTRE) sum += win[k];
      newh = (sum >>> 2) - older_centre;
      want.new_height = newh - (newh >>> cfg_shift);
      want.col = coord_type'(c - 1);
      want.row = coord_type'(r - 1);
      return 1'b1;
   endfunction

   function automatic height_type draw_height();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0:       return HEIGHT_MAX;
               1:       return HEIGHT_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2, 3: return height_type'($urandom);
         default: return height_type'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:   cfg_width  = value;
         CSR_FRAME_HEIGHT:  cfg_height = value;
         CSR_DAMPING_SHIFT: cfg_shift  = value[CFG_SHIFT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pixel_q.size() != 0 || req_bus.valid || ripple_q.size() != 0)
         @(posedge clock);
      // let border pixels still in the pipe clear out
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_pixel(input height_type cur, input height_type older, input logic sof);
      pixel_type px;
      px.cur = cur;
      px.older = older;
      px.sof = sof;
      px.after_drain = 1'b0;
      pixel_q.push_back(px);
   endtask

   task automatic push_run(input int unsigned count, input bit first_sof, input bit stray_sof);
      int unsigned i, stray_at;
      pixel_type   px;
      stray_at = stray_sof ? $urandom_range(1, count - 1) : count;
      for (i = 0; i < count; i++) begin
         px.cur = draw_height();
         px.older = draw_height();
         px.sof = (i == 0 && first_sof) || i == stray_at;
         px.after_drain = ($urandom_range(0, 127) == 0);
         pixel_q.push_back(px);
      end
   endtask

   // pixel driver: advance on each accepted transaction, predict at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (predict_ripple(req_bus.cur_height, req_bus.older_height,
                               req_bus.start_of_frame, next_ripple))
               ripple_q.push_back(next_ripple);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pixel_q.size() != 0 &&
                         (!pixel_q[0].after_drain || ripple_q.size() == 0)) begin
               next_pixel = pixel_q.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.cur_height     <= next_pixel.cur;
               req_bus.older_height   <= next_pixel.older;
               req_bus.start_of_frame <= next_pixel.sof;
               send_gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each transaction against the oldest predicted ripple
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_ripple.new_height = rsp_bus.new_height;
            got_ripple.col = rsp_bus.out_col;
            got_ripple.row = rsp_bus.out_row;
            if (ripple_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected ripple, expected none, got h=%0d col=%0d row=%0d",
                        $time, got_ripple.new_height, got_ripple.col, got_ripple.row);
            end else begin
               want_ripple = ripple_q.pop_front();
               if (got_ripple.new_height !== want_ripple.new_height ||
                   got_ripple.col !== want_ripple.col || got_ripple.row !== want_ripple.row) begin
                  mismatch_count++;
                  $display("%0t: ripple mismatch, expected h=%0d col=%0d row=%0d, ",
                           $time, want_ripple.new_height, want_ripple.col, want_ripple.row,
                           "got h=%0d col=%0d row=%0d",
                           got_ripple.new_height, got_ripple.col, got_ripple.row);
               end
            end
            rsp_stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned           i, k, n, count, first, frames, kind, random_items;
      logic [CSR_DATA_W-1:0] w_val, h_val, s_val;
      csr_index_type         idx;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cur_height = '0;
      req_bus.older_height = '0;
      req_bus.start_of_frame = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_FRAME_WIDTH;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;

      cfg_width  = FRAME_WIDTH_RST;
      cfg_height = FRAME_HEIGHT_RST;
      cfg_shift  = DAMPING_SHIFT_RST;
      row_above2 = '{default: '0};
      row_above1 = '{default: '0};
      older_ring = '{default: '0};
      win        = '{default: '0};
      ring_wr = 0;
      col_pos = 0;
      row_pos = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: widest frame, part of the first row
      push_run(40, 1'b1, 1'b0);
      wait_idle();
      // all-ones width clamps to the same effective width, so the row carries on
      write_reg(CSR_FRAME_WIDTH, '1);
      push_run(8, 1'b0, 1'b0);
      wait_idle();

      // shrink mid-row: column sits past the new width and wraps to the next row
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(MIN_SIZE));
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(MIN_SIZE + 1));
      write_reg(CSR_DAMPING_SHIFT, CSR_DATA_W'(17));
      push_run(2 * MIN_SIZE * (MIN_SIZE + 1), 1'b0, 1'b0);
      wait_idle();

      // shrink height mid-frame: row sits past the new height and wraps to row 0
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(MIN_SIZE + 7));
      push_run(MIN_SIZE * 6 + 1, 1'b1, 1'b0);
      wait_idle();
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(MIN_SIZE));
      push_run(MIN_SIZE * MIN_SIZE - 1, 1'b0, 1'b0);
      wait_idle();

      // smallest frame, saturated heights; damping shift of zero cancels everything
      write_reg(CSR_DAMPING_SHIFT, CSR_DATA_W'(0));
      for (i = 0; i < MIN_SIZE * MIN_SIZE; i++)
         push_pixel(HEIGHT_MAX, HEIGHT_MIN, i == 0);
      wait_idle();
      // no start marker: counters wrapped to the origin after the last pixel
      write_reg(CSR_DAMPING_SHIFT, CSR_DATA_W'(SHIFT_MAX));
      for (i = 0; i < MIN_SIZE * MIN_SIZE; i++)
         push_pixel(HEIGHT_MIN, HEIGHT_MAX, 1'b0);
      wait_idle();
      write_reg(CSR_DAMPING_SHIFT, CSR_DATA_W'(1));
      for (i = 0; i < MIN_SIZE * MIN_SIZE; i++)
         push_pixel(i[0] ? HEIGHT_MAX : HEIGHT_MIN, i[1] ? height_type'('1) : draw_height(),
                    i == 0);
      wait_idle();

      // below-range width and all-ones height clamp to a narrow, tall frame
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(MIN_SIZE - 1));
      write_reg(CSR_FRAME_HEIGHT, '1);
      write_reg(CSR_DAMPING_SHIFT, CSR_DATA_W'(DAMPING_SHIFT_RST));
      push_run(MIN_SIZE * 24, 1'b1, 1'b0);
      wait_idle();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w_val = CSR_DATA_W'($urandom_range(0, MIN_SIZE - 1));
            1:       w_val = CSR_DATA_W'($urandom_range(13, 40));
            default: w_val = CSR_DATA_W'($urandom_range(MIN_SIZE, 12));
         endcase
         if ($urandom_range(0, 9) == 0) h_val = CSR_DATA_W'($urandom_range(0, MIN_SIZE - 1));
         else h_val = CSR_DATA_W'($urandom_range(MIN_SIZE, 10));
         // upper data bits are don't-care for the shift register
         s_val = CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1));
         case ($urandom_range(0, 5))
            0:       s_val[CFG_SHIFT_W-1:0] = '0;
            1:       s_val[CFG_SHIFT_W-1:0] = '1;
            default: ;
         endcase
         steady_flow = ($urandom_range(0, 3) == 0);

         first = $urandom_range(0, NUM_REGS - 1);
         for (k = 0; k < NUM_REGS; k++) begin
            idx = csr_index_type'(CSR_IDX_W'((first + k) % NUM_REGS));
            case (idx)
               CSR_FRAME_WIDTH:  write_reg(idx, w_val);
               CSR_FRAME_HEIGHT: write_reg(idx, h_val);
               default:          write_reg(idx, s_val);
            endcase
         end

         n = effective_size(w_val) * effective_size(h_val);
         frames = $urandom_range(1, 4);
         for (k = 0; k < frames && random_items < RANDOM_ITEMS; k++) begin
            // mostly whole frames; some cut short, some without marker, some restarted
            kind = $urandom_range(0, 9);
            count = (kind == 7) ? $urandom_range(1, n - 1) : n;
            if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
            push_run(count, k == 0 || kind != 6, kind == 8);
            random_items += count;
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/wrss_pkg.sv
src/wrss_req_if.sv
src/wrss_rsp_if.sv
src/wrss_csr_if.sv
src/water_ripple_stencil_step_core.sv
tb/tb_water_ripple_stencil_step_core.sv
